// ===== rtl/mfe_pkg.sv =====
// ----------------------------------------------------------------------------
// mfe_pkg
// shared codes and types of the max flow engine
// ----------------------------------------------------------------------------
`default_nettype none

package mfe_pkg;

    // command codes of an input transfer
    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_RUN   = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_NODE_COUNT = 2'd0;
    localparam logic [1:0] CFG_SOURCE     = 2'd1;
    localparam logic [1:0] CFG_SINK       = 2'd2;

    // field widths fixed by the interface
    localparam int NODE_W  = 6;
    localparam int COUNT_W = 7;
    localparam int CAPIN_W = 16;
    localparam int TOTAL_W = 22;
    localparam int CFG_W   = 7;

    // operations of the shared residual unit
    typedef enum logic [1:0] {
        ALU_MIN    = 2'd0,
        ALU_SUB    = 2'd1,
        ALU_SATADD = 2'd2
    } t_alu_op;

endpackage

`default_nettype wire

// ===== rtl/mfe_ram.sv =====
// ----------------------------------------------------------------------------
// mfe_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module mfe_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                        i_wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/mfe_alu.sv =====
// ----------------------------------------------------------------------------
// mfe_alu
// shared residual unit: bottleneck minimum, forward subtract, saturating add
// ----------------------------------------------------------------------------
`default_nettype none

module mfe_alu #(
    parameter int W = 16
) (
    input  wire mfe_pkg::t_alu_op i_op,
    input  wire logic [W-1:0]     i_a,
    input  wire logic [W-1:0]     i_b,
    output logic      [W-1:0]     o_y
);

    logic [W:0] sum;

    assign sum = {1'b0, i_a} + {1'b0, i_b};

    // operation select
    always_comb begin
        case (i_op)
            mfe_pkg::ALU_MIN:    o_y = (i_a < i_b) ? i_a : i_b;
            mfe_pkg::ALU_SUB:    o_y = i_a - i_b;
            mfe_pkg::ALU_SATADD: o_y = sum[W] ? {W{1'b1}} : sum[W-1:0];
            default:             o_y = i_a;
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/max_flow_engine_top.sv =====
// ----------------------------------------------------------------------------
// max_flow_engine_top
// edmonds-karp maximum flow over a residual capacity matrix in ram
// ----------------------------------------------------------------------------
//  channel   | signals                                         | direction
//  command   | start, busy, i_command, i_from_node, i_to_node, | in, busy out
//            | i_capacity                                      |
//  result    | o_valid, o_total_flow                           | out
//  config    | i_cfg_we, i_cfg_idx, i_cfg_data                 | in
//
//  writes are taken back to back; clear sweeps all 2^(2*clog2(MAX_NODES))
//  matrix entries (4096 by default), one entry a cycle.
//  after reset the same clearing pass runs with busy high.
//  run: per search a setup step, per dequeued node a dequeue and a scan of its
//  neighbors, per path edge an augment step, then the final empty queue check;
//  paced by the single matrix ram port. o_valid pulses after busy falls; no stall.
// ----------------------------------------------------------------------------
`default_nettype none

module max_flow_engine_top #(
    parameter int MAX_NODES = 64,
    parameter int CAP_BITS  = 16
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic [1:0]                     i_command,
    input  wire logic [mfe_pkg::NODE_W-1:0]     i_from_node,
    input  wire logic [mfe_pkg::NODE_W-1:0]     i_to_node,
    input  wire logic [mfe_pkg::CAPIN_W-1:0]    i_capacity,
    output logic                                o_valid,
    output logic [mfe_pkg::TOTAL_W-1:0]         o_total_flow,
    input  wire logic                           i_cfg_we,
    input  wire logic [1:0]                     i_cfg_idx,
    input  wire logic [mfe_pkg::CFG_W-1:0]      i_cfg_data
);

    localparam int NB    = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int RD    = 1 << (2 * NB);
    localparam int SW    = (CAP_BITS > mfe_pkg::TOTAL_W) ? CAP_BITS : mfe_pkg::TOTAL_W;

    typedef enum logic [11:0] {
        ST_CLEAR  = 12'b000000000001,
        ST_IDLE   = 12'b000000000010,
        ST_INIT   = 12'b000000000100,
        ST_DEQ_Q  = 12'b000000001000,
        ST_DEQ_W  = 12'b000000010000,
        ST_DEQ_F  = 12'b000000100000,
        ST_SCAN_R = 12'b000001000000,
        ST_SCAN_E = 12'b000010000000,
        ST_AUG_P  = 12'b000100000000,
        ST_AUG_PW = 12'b001000000000,
        ST_AUG_FW = 12'b010000000000,
        ST_AUG_BW = 12'b100000000000
    } t_state;

    t_state r_state;
    logic   r_done;

    // configuration registers
    logic [mfe_pkg::COUNT_W-1:0] r_node_count;
    logic [mfe_pkg::NODE_W-1:0]  r_source;
    logic [mfe_pkg::NODE_W-1:0]  r_sink;

    // run state
    logic [NB:0]                 r_nodes;
    logic [NB-1:0]               r_src;
    logic [NB-1:0]               r_dst;
    logic [NB-1:0]               r_u;
    logic [NB-1:0]               r_v;
    logic [NB-1:0]               r_cur;
    logic [NB-1:0]               r_prev;
    logic [NB:0]                 r_head;
    logic [NB:0]                 r_tail;
    logic [CAP_BITS-1:0]         r_f;
    logic [MAX_NODES-1:0]        r_vis;
    logic [mfe_pkg::TOTAL_W-1:0] r_total;
    logic [mfe_pkg::TOTAL_W-1:0] n_total;
    logic [2*NB-1:0]             r_clr;

    // ram ports
    logic                res_we;
    logic [2*NB-1:0]     res_waddr;
    logic [CAP_BITS-1:0] res_wdata;
    logic [2*NB-1:0]     res_raddr;
    logic [CAP_BITS-1:0] res_rdata;
    logic                par_we;
    logic [NB-1:0]       par_raddr;
    logic [NB-1:0]       par_rdata;
    logic                que_we;
    logic [NB-1:0]       que_waddr;
    logic [NB-1:0]       que_wdata;
    logic [NB-1:0]       que_rdata;
    logic                bn_we;
    logic [NB-1:0]       bn_waddr;
    logic [CAP_BITS-1:0] bn_wdata;
    logic [CAP_BITS-1:0] bn_rdata;

    // shared unit
    mfe_pkg::t_alu_op    alu_op;
    logic [CAP_BITS-1:0] alu_a;
    logic [CAP_BITS-1:0] alu_b;
    logic [CAP_BITS-1:0] alu_y;

    logic wr_ok;
    logic take;
    logic edge_ok;
    logic last_v;
    logic [NB:0] eff_nodes;
    logic run_bad;

    assign busy  = (r_state != ST_IDLE);
    assign take  = start && !busy;
    assign wr_ok = (int'(i_from_node) < MAX_NODES) && (int'(i_to_node) < MAX_NODES);
    assign edge_ok = !r_vis[r_v] && (res_rdata != '0);
    assign last_v  = ({1'b0, r_v} == (r_nodes - 1'b1));
    assign eff_nodes = (int'(r_node_count) > MAX_NODES) ? (NB+1)'(MAX_NODES)
                                                        : (NB+1)'(r_node_count);
    assign run_bad = (r_source == r_sink) || (int'(r_source) >= int'(eff_nodes))
                     || (int'(r_sink) >= int'(eff_nodes));
    assign n_total = mfe_pkg::TOTAL_W'(SW'(r_total) + SW'(alu_y));

    mfe_alu #(.W(CAP_BITS)) u_alu (
        .i_op (alu_op),
        .i_a  (alu_a),
        .i_b  (alu_b),
        .o_y  (alu_y)
    );

    mfe_ram #(.WIDTH(CAP_BITS), .DEPTH(RD)) u_res (
        .i_clk   (i_clk),
        .i_we    (res_we),
        .i_waddr (res_waddr),
        .i_wdata (res_wdata),
        .i_raddr (res_raddr),
        .o_rdata (res_rdata)
    );

    mfe_ram #(.WIDTH(NB), .DEPTH(MAX_NODES)) u_par (
        .i_clk   (i_clk),
        .i_we    (par_we),
        .i_waddr (r_v),
        .i_wdata (r_u),
        .i_raddr (par_raddr),
        .o_rdata (par_rdata)
    );

    mfe_ram #(.WIDTH(NB), .DEPTH(MAX_NODES)) u_que (
        .i_clk   (i_clk),
        .i_we    (que_we),
        .i_waddr (que_waddr),
        .i_wdata (que_wdata),
        .i_raddr (r_head[NB-1:0]),
        .o_rdata (que_rdata)
    );

    mfe_ram #(.WIDTH(CAP_BITS), .DEPTH(MAX_NODES)) u_bn (
        .i_clk   (i_clk),
        .i_we    (bn_we),
        .i_waddr (bn_waddr),
        .i_wdata (bn_wdata),
        .i_raddr (que_rdata),
        .o_rdata (bn_rdata)
    );

    // ram and shared unit control
    always_comb begin
        res_we    = 1'b0;
        res_waddr = {NB'(i_from_node), NB'(i_to_node)};
        res_wdata = CAP_BITS'(i_capacity);
        res_raddr = {r_u, r_v};
        par_we    = 1'b0;
        par_raddr = r_cur;
        que_we    = 1'b0;
        que_waddr = r_tail[NB-1:0];
        que_wdata = r_v;
        bn_we     = 1'b0;
        bn_waddr  = r_v;
        bn_wdata  = alu_y;
        alu_op    = mfe_pkg::ALU_MIN;
        alu_a     = r_f;
        alu_b     = res_rdata;
        case (r_state)
            ST_CLEAR: begin
                res_we    = 1'b1;
                res_waddr = r_clr;
                res_wdata = '0;
            end
            ST_IDLE: begin
                res_we = take && (i_command == mfe_pkg::CMD_WRITE) && wr_ok;
            end
            ST_INIT: begin
                que_we    = 1'b1;
                que_waddr = '0;
                que_wdata = r_src;
                bn_we     = 1'b1;
                bn_waddr  = r_src;
                bn_wdata  = {CAP_BITS{1'b1}};
            end
            ST_SCAN_E: begin
                par_we = edge_ok;
                bn_we  = edge_ok;
                que_we = edge_ok && (r_v != r_dst) && (int'(r_tail) < MAX_NODES);
            end
            ST_AUG_PW: begin
                res_raddr = {par_rdata, r_cur};
            end
            ST_AUG_FW: begin
                alu_op    = mfe_pkg::ALU_SUB;
                alu_a     = res_rdata;
                alu_b     = r_f;
                res_we    = 1'b1;
                res_waddr = {r_prev, r_cur};
                res_wdata = alu_y;
                res_raddr = {r_cur, r_prev};
            end
            ST_AUG_BW: begin
                alu_op    = mfe_pkg::ALU_SATADD;
                alu_a     = res_rdata;
                alu_b     = r_f;
                res_we    = 1'b1;
                res_waddr = {r_cur, r_prev};
                res_wdata = alu_y;
            end
            default: begin
            end
        endcase
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= mfe_pkg::COUNT_W'(64);
            r_source     <= '0;
            r_sink       <= mfe_pkg::NODE_W'(63);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                mfe_pkg::CFG_NODE_COUNT: r_node_count <= i_cfg_data;
                mfe_pkg::CFG_SOURCE:     r_source <= i_cfg_data[mfe_pkg::NODE_W-1:0];
                mfe_pkg::CFG_SINK:       r_sink   <= i_cfg_data[mfe_pkg::NODE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r_done;
        end
        if (r_done) begin
            o_total_flow <= r_total;
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_done  <= 1'b0;
            r_clr   <= '0;
            r_total <= '0;
            r_head  <= '0;
            r_tail  <= '0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                ST_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == (2*NB)'(RD - 1)) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (take && (i_command == mfe_pkg::CMD_CLEAR)) begin
                        r_clr   <= '0;
                        r_total <= '0;
                        r_state <= ST_CLEAR;
                    end else if (take && (i_command == mfe_pkg::CMD_RUN)) begin
                        r_total <= '0;
                        r_nodes <= eff_nodes;
                        r_src   <= NB'(r_source);
                        r_dst   <= NB'(r_sink);
                        if (run_bad) begin
                            r_done <= 1'b1;
                        end else begin
                            r_state <= ST_INIT;
                        end
                    end
                end
                ST_INIT: begin
                    r_vis   <= {{(MAX_NODES-1){1'b0}}, 1'b1} << r_src;
                    r_head  <= '0;
                    r_tail  <= (NB+1)'(1);
                    r_state <= ST_DEQ_Q;
                end
                ST_DEQ_Q: begin
                    if (r_head == r_tail) begin
                        r_done  <= 1'b1;
                        r_state <= ST_IDLE;
                    end else begin
                        r_state <= ST_DEQ_W;
                    end
                end
                ST_DEQ_W: begin
                    r_head  <= r_head + 1'b1;
                    r_u     <= que_rdata;
                    r_state <= ST_DEQ_F;
                end
                ST_DEQ_F: begin
                    r_f     <= bn_rdata;
                    r_v     <= '0;
                    r_state <= ST_SCAN_R;
                end
                ST_SCAN_R: begin
                    r_state <= ST_SCAN_E;
                end
                ST_SCAN_E: begin
                    if (edge_ok) begin
                        r_vis[r_v] <= 1'b1;
                    end
                    if (edge_ok && (r_v == r_dst)) begin
                        r_f     <= alu_y;
                        r_total <= n_total;
                        r_cur   <= r_dst;
                        r_state <= ST_AUG_P;
                    end else begin
                        if (edge_ok && (int'(r_tail) < MAX_NODES)) begin
                            r_tail <= r_tail + 1'b1;
                        end
                        if (last_v) begin
                            r_state <= ST_DEQ_Q;
                        end else begin
                            r_v     <= r_v + 1'b1;
                            r_state <= ST_SCAN_R;
                        end
                    end
                end
                ST_AUG_P: begin
                    r_state <= ST_AUG_PW;
                end
                ST_AUG_PW: begin
                    r_prev  <= par_rdata;
                    r_state <= ST_AUG_FW;
                end
                ST_AUG_FW: begin
                    r_state <= ST_AUG_BW;
                end
                ST_AUG_BW: begin
                    r_cur <= r_prev;
                    if (r_prev == r_src) begin
                        r_state <= ST_INIT;
                    end else begin
                        r_state <= ST_AUG_P;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTH
    // a result only follows the end of a run
    a_valid_after_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_done))
        else $error("result without finished run");

    // queue pointers stay ordered and bounded
    a_queue_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_head <= r_tail) && (int'(r_tail) <= MAX_NODES))
        else $error("queue pointers out of order");

    // an accepted clear starts the sweep and raises busy
    a_clear_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && (i_command == mfe_pkg::CMD_CLEAR)) |=> busy)
        else $error("clear did not start sweep");

    // augment never walks a self edge
    a_aug_no_self: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_AUG_FW) |-> (r_prev != r_cur))
        else $error("augment on self loop");
`endif

endmodule

`default_nettype wire
